@@ rtl/core/srf_pkg.sv @@
// shared types and constants for the section repeat filter
package srf_pkg;

    localparam int MAX_SECTION_DEF = 512;
    localparam int MIN_SECTION     = 3;
    localparam int OUTQ_DEPTH      = 3;
    localparam int SIZE_W          = 10;
    localparam int BYTE_W          = 8;

    localparam logic [BYTE_W-1:0] TID_FIRST  = 8'h80;
    localparam logic [BYTE_W-1:0] TID_SECOND = 8'h81;

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_TAKE  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_NEW        = 3'd0,
        ST_REPEAT     = 3'd1,
        ST_BAD_LENGTH = 3'd2,
        ST_BAD_TABLE  = 3'd3,
        ST_DONE       = 3'd4
    } t_status;

    typedef logic [1:0] t_bank;

    localparam t_bank BANK0 = 2'd0;
    localparam t_bank BANK1 = 2'd1;
    localparam t_bank BANK2 = 2'd2;

    typedef struct packed {
        t_status           status;
        logic [SIZE_W-1:0] size;
        logic              rd_hit;
    } t_result;

    typedef struct packed {
        t_status           status;
        logic [SIZE_W-1:0] size;
        logic [BYTE_W-1:0] rd_byte;
    } t_out;

endpackage

@@ rtl/core/section_repeat_filter_top.sv @@
// top level of the section repeat filter
// a result passes the ctrl result register, then the output queue, to the master side
// throughput: one transaction per cycle while the output queue has room, section bytes
//   included, set by one bank write per byte with the compare byte fetched ahead
// reset: synchronous active low; banks, lengths and queue clear at once, the byte
//   memory is not cleared and needs no clearing pass
module section_repeat_filter_top #(
    parameter int MAX_SECTION = srf_pkg::MAX_SECTION_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // data_byte, read_index, zero pad
    input  logic [1:0]  s_axis_tuser,   // command
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // section_size, read_byte, zero pad
    output logic [2:0]  m_axis_tuser    // status
);
    import srf_pkg::*;

    localparam int AW = $clog2(3 * MAX_SECTION);

    logic              accept;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [BYTE_W-1:0] wdata;
    logic [AW-1:0]     raddr_a;
    logic              re_b;
    logic [AW-1:0]     raddr_b;
    logic [BYTE_W-1:0] q_a;
    logic [BYTE_W-1:0] q_b;
    logic              res_valid;
    t_result           res;
    t_out              item;

    assign accept = s_axis_tvalid && s_axis_tready;

    srf_ctrl #(
        .MAX_SECTION(MAX_SECTION)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_cmd      (t_cmd'(s_axis_tuser)),
        .i_data     (s_axis_tdata[7:0]),
        .i_last     (s_axis_tlast),
        .i_idx      (s_axis_tdata[16:8]),
        .i_pref     (q_a),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr_a  (raddr_a),
        .o_re_b     (re_b),
        .o_raddr_b  (raddr_b),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    srf_store #(
        .MAX_SECTION(MAX_SECTION)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr_a(raddr_a),
        .i_re_b   (re_b),
        .i_raddr_b(raddr_b),
        .o_q_a    (q_a),
        .o_q_b    (q_b)
    );

    srf_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_valid),
        .i_res    (res),
        .i_rd_byte(q_b),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_item   (item),
        .o_room   (s_axis_tready)
    );

    assign m_axis_tdata = {6'b0, item.rd_byte, item.size};
    assign m_axis_tuser = item.status;

endmodule

@@ rtl/core/srf_store.sv @@
// three-bank section byte memory, one write port and two registered read ports
module srf_store #(
    parameter int MAX_SECTION = srf_pkg::MAX_SECTION_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [$clog2(3*MAX_SECTION)-1:0]     i_waddr,
    input  logic [srf_pkg::BYTE_W-1:0]           i_wdata,
    input  logic [$clog2(3*MAX_SECTION)-1:0]     i_raddr_a,
    input  logic                                 i_re_b,
    input  logic [$clog2(3*MAX_SECTION)-1:0]     i_raddr_b,
    output logic [srf_pkg::BYTE_W-1:0]           o_q_a,
    output logic [srf_pkg::BYTE_W-1:0]           o_q_b
);
    import srf_pkg::*;

    localparam int DEPTH = 3 * MAX_SECTION;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_q_a;
    logic [BYTE_W-1:0] r_q_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q_a <= r_mem[i_raddr_a];
        if (i_re_b) begin
            r_q_b <= r_mem[i_raddr_b];
        end
    end

    assign o_q_a = r_q_a;
    assign o_q_b = r_q_b;

endmodule

@@ rtl/core/srf_ctrl.sv @@
// bank rotation, section checks and command decode
module srf_ctrl #(
    parameter int MAX_SECTION = srf_pkg::MAX_SECTION_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  srf_pkg::t_cmd                        i_cmd,
    input  logic [srf_pkg::BYTE_W-1:0]           i_data,
    input  logic                                 i_last,
    input  logic [8:0]                           i_idx,
    input  logic [srf_pkg::BYTE_W-1:0]           i_pref,
    output logic                                 o_we,
    output logic [$clog2(3*MAX_SECTION)-1:0]     o_waddr,
    output logic [srf_pkg::BYTE_W-1:0]           o_wdata,
    output logic [$clog2(3*MAX_SECTION)-1:0]     o_raddr_a,
    output logic                                 o_re_b,
    output logic [$clog2(3*MAX_SECTION)-1:0]     o_raddr_b,
    output logic                                 o_res_valid,
    output srf_pkg::t_result                     o_res
);
    import srf_pkg::*;

    localparam int CW = $clog2(MAX_SECTION + 2);
    localparam int AW = $clog2(3 * MAX_SECTION);
    localparam int XW = (CW > 9) ? CW : 9;

    localparam logic [CW-1:0] MAX_C  = CW'(MAX_SECTION);
    localparam logic [CW-1:0] MAX_P1 = CW'(MAX_SECTION + 1);
    localparam logic [CW-1:0] MIN_C  = CW'(MIN_SECTION);

    t_bank         r_stage, n_stage;
    t_bank         r_pend, n_pend;
    t_bank         r_taken, n_taken;
    logic [CW-1:0] r_pend_len, n_pend_len;
    logic [CW-1:0] r_taken_len, n_taken_len;
    logic [CW-1:0] r_count, n_count;
    logic          r_diff, n_diff;
    logic          r_bad, n_bad;
    logic          r_res_valid, n_res_valid;
    t_result       r_res, n_res;

    logic          byte_ok;
    logic          cmp_hit;
    logic          diff_now;
    logic          bad_now;
    logic          idx_hit;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] n_pos;

    function automatic logic [AW-1:0] bank_base(input t_bank b);
        logic [AW-1:0] base;
        case (b)
            BANK0:   base = '0;
            BANK1:   base = AW'(MAX_SECTION);
            default: base = AW'(2 * MAX_SECTION);
        endcase
        return base;
    endfunction

    assign byte_ok  = r_count < MAX_C;
    assign cmp_hit  = byte_ok && (r_count < r_taken_len);
    assign diff_now = r_diff | (cmp_hit && (i_pref != i_data));
    assign bad_now  = (r_count == '0) ? ((i_data != TID_FIRST) && (i_data != TID_SECOND))
                                      : r_bad;
    assign cnt_inc  = (r_count == MAX_P1) ? MAX_P1 : r_count + CW'(1);
    assign idx_hit  = XW'(i_idx) < XW'(r_taken_len);

    always_comb begin
        n_stage     = r_stage;
        n_pend      = r_pend;
        n_taken     = r_taken;
        n_pend_len  = r_pend_len;
        n_taken_len = r_taken_len;
        n_count     = r_count;
        n_diff      = r_diff;
        n_bad       = r_bad;
        n_res_valid = 1'b0;
        n_res       = '{status: ST_DONE, size: '0, rd_hit: 1'b0};
        o_we        = 1'b0;
        o_re_b      = 1'b0;
        if (i_accept) begin
            unique case (i_cmd)
                CMD_BYTE: begin
                    o_we = byte_ok;
                    if (!i_last) begin
                        n_count = cnt_inc;
                        n_diff  = diff_now;
                        n_bad   = bad_now;
                    end else begin
                        n_res_valid = 1'b1;
                        n_count     = '0;
                        n_diff      = 1'b0;
                        n_bad       = 1'b0;
                        if ((cnt_inc < MIN_C) || (cnt_inc > MAX_C)) begin
                            n_res.status = ST_BAD_LENGTH;
                        end else if (bad_now) begin
                            n_res.status = ST_BAD_TABLE;
                        end else if ((cnt_inc == r_taken_len) && !diff_now) begin
                            n_res.status = ST_REPEAT;
                        end else begin
                            n_res.status = ST_NEW;
                            n_res.size   = SIZE_W'(cnt_inc);
                            n_stage      = r_pend;
                            n_pend       = r_stage;
                            n_pend_len   = cnt_inc;
                        end
                    end
                end
                CMD_TAKE: begin
                    n_res_valid = 1'b1;
                    n_res.size  = SIZE_W'(r_pend_len);
                    if (r_pend_len != '0) begin
                        n_taken     = r_pend;
                        n_pend      = r_taken;
                        n_taken_len = r_pend_len;
                        n_pend_len  = '0;
                        if (r_count != '0) begin
                            n_diff = 1'b1;
                        end
                    end
                end
                CMD_READ: begin
                    n_res_valid  = 1'b1;
                    n_res.size   = SIZE_W'(r_taken_len);
                    n_res.rd_hit = idx_hit;
                    o_re_b       = idx_hit;
                end
                CMD_CLEAR: begin
                    n_res_valid = 1'b1;
                    n_pend_len  = '0;
                    n_taken_len = '0;
                end
            endcase
        end
    end

    // taken byte at the next write position is fetched ahead through the registered read port
    assign n_pos     = (n_count < MAX_C) ? n_count : '0;
    assign o_raddr_a = bank_base(n_taken) + AW'(n_pos);
    assign o_waddr   = bank_base(r_stage) + AW'(r_count);
    assign o_wdata   = i_data;
    assign o_raddr_b = bank_base(r_taken) + AW'(i_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= BANK0;
            r_pend      <= BANK1;
            r_taken     <= BANK2;
            r_pend_len  <= '0;
            r_taken_len <= '0;
            r_count     <= '0;
            r_diff      <= 1'b0;
            r_bad       <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_stage     <= n_stage;
            r_pend      <= n_pend;
            r_taken     <= n_taken;
            r_pend_len  <= n_pend_len;
            r_taken_len <= n_taken_len;
            r_count     <= n_count;
            r_diff      <= n_diff;
            r_bad       <= n_bad;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

@@ rtl/core/srf_outq.sv @@
// result queue that merges the read byte and decouples the output handshake
module srf_outq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  srf_pkg::t_result            i_res,
    input  logic [srf_pkg::BYTE_W-1:0]  i_rd_byte,
    input  logic                        i_ready,
    output logic                        o_valid,
    output srf_pkg::t_out               o_item,
    output logic                        o_room
);
    import srf_pkg::*;

    localparam int PW = $clog2(OUTQ_DEPTH);
    localparam int NW = $clog2(OUTQ_DEPTH + 1);

    localparam logic [PW-1:0] LAST_PTR = PW'(OUTQ_DEPTH - 1);

    t_out          r_q [OUTQ_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [NW-1:0] r_cnt, n_cnt;
    logic          pop;
    t_out          push_item;

    assign pop     = (r_cnt != '0) && i_ready;
    assign o_valid = r_cnt != '0;
    assign o_item  = r_q[r_rp];

    // room counts the result still one stage ahead of the queue
    assign o_room = ({1'b0, r_cnt} + (NW + 1)'(i_push)) < (NW + 1)'(OUTQ_DEPTH);

    always_comb begin
        push_item.status  = i_res.status;
        push_item.size    = i_res.size;
        push_item.rd_byte = i_res.rd_hit ? i_rd_byte : '0;
    end

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == LAST_PTR) ? '0 : r_wp + PW'(1);
        end
        if (pop) begin
            n_rp = (r_rp == LAST_PTR) ? '0 : r_rp + PW'(1);
        end
        if (i_push && !pop) begin
            n_cnt = r_cnt + NW'(1);
        end else if (!i_push && pop) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= push_item;
        end
    end

endmodule
